// ----- sv/adcu_pkg.sv -----
// Package for the accelerometer direction cosine unit.
// Holds fixed widths, request types and register indexes; no dependencies.
`default_nettype none
package adcu_pkg;

	localparam int WordWidth = 16;
	localparam int CosFrac   = 14;
	localparam int AccelWidth = 20;
	localparam int CosWidth   = 16;
	localparam int RootWidth  = WordWidth;
	localparam int SumWidth   = 2 * WordWidth;
	localparam int QuotBits   = CosFrac + 1;
	localparam int DivWidth   = WordWidth + CosFrac;

	localparam logic [3:0] CFG_BITS_IN_USE = 4'd0;
	localparam logic [3:0] CFG_G_RANGE     = 4'd1;

	typedef struct packed {
		logic signed [15:0] x_word;
		logic signed [15:0] y_word;
		logic signed [15:0] z_word;
	} in_req_t;

	typedef struct packed {
		logic signed [19:0] x_accel;
		logic signed [19:0] y_accel;
		logic signed [19:0] z_accel;
		logic signed [15:0] x_cosine;
		logic signed [15:0] y_cosine;
		logic signed [15:0] z_cosine;
		logic               zero_vector;
	} out_rsp_t;

	// Per-sample information carried beside the root computation.
	typedef struct packed {
		logic [2:0][AccelWidth-1:0] accel;
		logic [2:0][WordWidth-1:0]  mag;
		logic [2:0]                 neg;
		logic                       zero;
	} side_t;

endpackage
`default_nettype wire

// ----- sv/accel_direction_cosines_unit.sv -----
// Top level of the accelerometer direction cosine unit.
// Depends on adcu_pkg, adcu_lane, adcu_sqrt and adcu_div.
//
//  channel  | signals                          | carries
//  in       | in_valid, in_ready, in_req       | three raw axis words
//  out      | out_valid, out_ready, out_rsp    | accelerations, cosines, zero flag
//  cfg      | cfg_valid, cfg_ready, cfg_index, | register writes, always ready
//           | cfg_data                         |
//
// One request is taken per cycle unless an unaccepted result waits at the output.
// The stages are the lane stage, the sum stage, one square root stage per root bit,
// one divider stage per quotient bit and the output register. The whole pipeline advances
// together and holds while a result waits at the output. Reset clears valid flags and
// registers bits_in_use to 14 and g_range to 2.
`default_nettype none
module accel_direction_cosines_unit import adcu_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire in_req_t    in_req,
	output logic            out_valid,
	input  wire logic       out_ready,
	output out_rsp_t        out_rsp,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [3:0] cfg_index,
	input  wire logic [4:0] cfg_data
);
	localparam int Depth = 2 + RootWidth + QuotBits;

	logic [4:0] bits_q;
	logic [4:0] range_q;
	logic [4:0] bits_act;
	logic [4:0] range_act;
	logic [3:0] drop;
	logic       adv;
	logic       vld_q [Depth];
	logic       out_valid_q;
	out_rsp_t   out_q;

	logic [2:0][AccelWidth-1:0] accel_s1;
	logic [2:0][WordWidth-1:0]  mag_s1;
	logic [2:0]                 neg_s1;
	logic [2:0][SumWidth-1:0]   square_s1;
	logic [SumWidth-1:0]        sum_s2;
	side_t                      side_s2;
	logic [RootWidth-1:0]       root;
	side_t                      side_root;
	side_t                      side_d [QuotBits];
	logic [2:0][QuotBits-1:0]   quot;
	logic [2:0][CosWidth-1:0]   cosine;
	logic [15:0]                words [3];

	assign adv       = !out_valid_q || out_ready;
	assign in_ready  = adv;
	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q  <= 5'd14;
			range_q <= 5'd2;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_BITS_IN_USE) bits_q <= cfg_data;
			if (cfg_index == CFG_G_RANGE) range_q <= cfg_data;
		end
	end

	// Saturate the register values into their working ranges.
	always_comb begin
		bits_act  = (bits_q < 5'd8) ? 5'd8 :
			(bits_q > 5'(WordWidth)) ? 5'(WordWidth) : bits_q;
		range_act = (range_q < 5'd1) ? 5'd1 : (range_q > 5'd16) ? 5'd16 : range_q;
		drop      = 4'(5'(WordWidth) - bits_act);
	end

	assign words[0] = in_req.x_word;
	assign words[1] = in_req.y_word;
	assign words[2] = in_req.z_word;

	for (genvar k = 0; k < 3; k++) begin : g_lane
		adcu_lane u_lane (
			.clk       (clk),
			.en        (adv),
			.word      (words[k]),
			.drop      (drop),
			.range     (range_act),
			.accel_s1  (accel_s1[k]),
			.mag_s1    (mag_s1[k]),
			.neg_s1    (neg_s1[k]),
			.square_s1 (square_s1[k])
		);
	end

	// Merge the lanes: sum of squares and the zero vector flag.
	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s2        <= square_s1[0] + square_s1[1] + square_s1[2];
			side_s2.accel <= accel_s1;
			side_s2.mag   <= mag_s1;
			side_s2.neg   <= neg_s1;
			side_s2.zero  <= (mag_s1[0] == '0) && (mag_s1[1] == '0) && (mag_s1[2] == '0);
		end
	end

	adcu_sqrt u_sqrt (
		.clk      (clk),
		.en       (adv),
		.sum      (sum_s2),
		.side_in  (side_s2),
		.root     (root),
		.side_out (side_root)
	);

	for (genvar k = 0; k < 3; k++) begin : g_div
		adcu_div u_div (
			.clk  (clk),
			.en   (adv),
			.mag  (side_root.mag[k]),
			.root (root),
			.quot (quot[k])
		);
	end

	// Carry the side data beside the dividers.
	always_ff @(posedge clk) begin
		if (adv) begin
			side_d[0] <= side_root;
			for (int i = 1; i < QuotBits; i++) begin
				side_d[i] <= side_d[i-1];
			end
		end
	end

	// Saturate to unity, apply the sign and force zero for a zero vector.
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			logic [CosWidth-1:0] mag_c;
			mag_c = (quot[k] > QuotBits'(1 << CosFrac)) ? CosWidth'(1 << CosFrac)
				: CosWidth'(quot[k]);
			if (side_d[QuotBits-1].zero) begin
				cosine[k] = '0;
			end else begin
				cosine[k] = side_d[QuotBits-1].neg[k] ? CosWidth'(-mag_c) : mag_c;
			end
		end
	end

	// Valid flags along the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < Depth; i++) vld_q[i] <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			vld_q[0] <= in_valid;
			for (int i = 1; i < Depth; i++) vld_q[i] <= vld_q[i-1];
			out_valid_q <= vld_q[Depth-1];
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (adv) begin
			out_q.x_accel     <= side_d[QuotBits-1].accel[0];
			out_q.y_accel     <= side_d[QuotBits-1].accel[1];
			out_q.z_accel     <= side_d[QuotBits-1].accel[2];
			out_q.x_cosine    <= cosine[0];
			out_q.y_cosine    <= cosine[1];
			out_q.z_cosine    <= cosine[2];
			out_q.zero_vector <= side_d[QuotBits-1].zero;
		end
	end

	assign out_valid = out_valid_q;
	assign out_rsp   = out_q;
endmodule
`default_nettype wire

// ----- sv/adcu_lane.sv -----
// One axis lane: flag clearing, range scaling and squaring, one register stage.
// Depends on adcu_pkg.
`default_nettype none
module adcu_lane import adcu_pkg::*; (
	input  wire logic                         clk,
	input  wire logic                         en,
	input  wire logic [15:0]                  word,
	input  wire logic [3:0]                   drop,
	input  wire logic [4:0]                   range,
	output logic      [AccelWidth-1:0]        accel_s1,
	output logic      [WordWidth-1:0]         mag_s1,
	output logic                              neg_s1,
	output logic      [SumWidth-1:0]          square_s1
);
	logic signed [WordWidth-1:0]   aligned;
	logic signed [WordWidth+5:0]   scaled;
	logic signed [SumWidth-1:0]    square;

	// Clear the low flag bits, then scale and square the aligned value.
	always_comb begin
		aligned = $signed(word[WordWidth-1:0] & ({WordWidth{1'b1}} << drop));
		scaled  = aligned * $signed({1'b0, range});
		square  = aligned * aligned;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			accel_s1  <= scaled[AccelWidth-1:0];
			neg_s1    <= aligned[WordWidth-1];
			mag_s1    <= aligned[WordWidth-1] ? WordWidth'(-aligned) : WordWidth'(aligned);
			square_s1 <= SumWidth'(square);
		end
	end
endmodule
`default_nettype wire

// ----- sv/adcu_sqrt.sv -----
// Pipelined integer square root, one root bit per stage, side data alongside.
// Depends on adcu_pkg.
`default_nettype none
module adcu_sqrt import adcu_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 en,
	input  wire logic [SumWidth-1:0]  sum,
	input  wire side_t                side_in,
	output logic      [RootWidth-1:0] root,
	output side_t                     side_out
);
	logic [RootWidth+1:0] rem_s  [RootWidth];
	logic [RootWidth-1:0] root_s [RootWidth];
	logic [SumWidth-1:0]  n_s    [RootWidth];
	side_t                side_s [RootWidth];

	for (genvar g = 0; g < RootWidth; g++) begin : g_stage
		logic [RootWidth+1:0] rem_p;
		logic [RootWidth-1:0] root_p;
		logic [SumWidth-1:0]  n_p;
		side_t                side_p;
		logic [RootWidth+3:0] trial;
		logic [RootWidth+3:0] test;
		logic [RootWidth+3:0] diff;

		if (g == 0) begin : g_first
			assign rem_p  = '0;
			assign root_p = '0;
			assign n_p    = sum;
			assign side_p = side_in;
		end else begin : g_next
			assign rem_p  = rem_s[g-1];
			assign root_p = root_s[g-1];
			assign n_p    = n_s[g-1];
			assign side_p = side_s[g-1];
		end

		// Bring down two radicand bits and try the next root bit.
		always_comb begin
			trial = {rem_p, n_p[SumWidth-1 -: 2]};
			test  = {2'b00, root_p, 2'b01};
			diff  = trial - test;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				n_s[g]    <= n_p << 2;
				side_s[g] <= side_p;
				if (trial >= test) begin
					rem_s[g]  <= diff[RootWidth+1:0];
					root_s[g] <= {root_p[RootWidth-2:0], 1'b1};
				end else begin
					rem_s[g]  <= trial[RootWidth+1:0];
					root_s[g] <= {root_p[RootWidth-2:0], 1'b0};
				end
			end
		end
	end

	assign root     = root_s[RootWidth-1];
	assign side_out = side_s[RootWidth-1];
endmodule
`default_nettype wire

// ----- sv/adcu_div.sv -----
// Pipelined restoring divider for one lane: (mag << CosFrac) / root,
// one quotient bit per stage. Depends on adcu_pkg.
`default_nettype none
module adcu_div import adcu_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 en,
	input  wire logic [WordWidth-1:0] mag,
	input  wire logic [RootWidth-1:0] root,
	output logic      [QuotBits-1:0]  quot
);
	logic [RootWidth:0]   rem_s  [QuotBits];
	logic [QuotBits-1:0]  low_s  [QuotBits];
	logic [RootWidth-1:0] dvs_s  [QuotBits];
	logic [QuotBits-1:0]  quot_s [QuotBits];
	logic [DivWidth-1:0]  dividend;

	assign dividend = {mag, {CosFrac{1'b0}}};

	for (genvar g = 0; g < QuotBits; g++) begin : g_stage
		logic [RootWidth:0]   rem_p;
		logic [QuotBits-1:0]  low_p;
		logic [RootWidth-1:0] dvs_p;
		logic [QuotBits-1:0]  quot_p;
		logic [RootWidth:0]   shifted;
		logic                 fits;

		if (g == 0) begin : g_first
			// The top part of the dividend is already below the divisor.
			assign rem_p  = (RootWidth+1)'(dividend[DivWidth-1:QuotBits]);
			assign low_p  = dividend[QuotBits-1:0];
			assign dvs_p  = root;
			assign quot_p = '0;
		end else begin : g_next
			assign rem_p  = rem_s[g-1];
			assign low_p  = low_s[g-1];
			assign dvs_p  = dvs_s[g-1];
			assign quot_p = quot_s[g-1];
		end

		always_comb begin
			shifted = {rem_p[RootWidth-1:0], low_p[QuotBits-1]};
			fits    = shifted >= {1'b0, dvs_p};
		end

		always_ff @(posedge clk) begin
			if (en) begin
				low_s[g]  <= low_p << 1;
				dvs_s[g]  <= dvs_p;
				quot_s[g] <= {quot_p[QuotBits-2:0], fits};
				rem_s[g]  <= fits ? shifted - {1'b0, dvs_p} : shifted;
			end
		end
	end

	assign quot = quot_s[QuotBits-1];
endmodule
`default_nettype wire

// ----- bench/accel_direction_cosines_unit_tb.sv -----
// Self-checking bench for the accelerometer direction cosine unit.
// Depends on adcu_pkg and the accel_direction_cosines_unit top level.
`default_nettype none
module accel_direction_cosines_unit_tb;
	import adcu_pkg::*;

	localparam int LATENCY = 34;
	localparam logic [3:0] CFG_UNUSED = 4'd9;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_req_t in_req;
	logic out_valid;
	logic out_ready;
	out_rsp_t out_rsp;
	logic cfg_valid;
	logic cfg_ready;
	logic [3:0] cfg_index;
	logic [4:0] cfg_data;

	accel_direction_cosines_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_req(in_req),
		.out_valid(out_valid), .out_ready(out_ready), .out_rsp(out_rsp),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Bench copy of the two registers.
	logic [4:0] bits_reg;
	logic [4:0] range_reg;

	in_req_t  sample_queue[$];
	out_rsp_t expected_rsp[$];
	int       error_count;
	int       result_count;
	int       send_idle_pct;
	int       recv_idle_pct;
	int       hold_cycles;
	bit       config_pending;
	logic [3:0] config_index;
	logic [4:0] config_data;

	// Clock.
	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Floor of the square root, bit by bit.
	function automatic logic [31:0] root_floor(input logic [63:0] n);
		logic [63:0] root;
		logic [63:0] bit_val;
		begin
			root = 0;
			bit_val = 64'd1 << 40;
			while (bit_val > n)
				bit_val = bit_val >> 2;
			while (bit_val != 0) begin
				if (n >= root + bit_val) begin
					n = n - (root + bit_val);
					root = (root >> 1) + bit_val;
				end else begin
					root = root >> 1;
				end
				bit_val = bit_val >> 2;
			end
			return root[31:0];
		end
	endfunction

	// Predicts the normalized result for one sample under the current registers.
	function automatic out_rsp_t normalize_sample(input in_req_t s);
		out_rsp_t r;
		int unsigned keep;
		int unsigned scale;
		logic [15:0] words[3];
		longint aligned[3];
		longint mag;
		longint q;
		logic [63:0] sum;
		logic [31:0] root;
		logic [15:0] mask;
		begin
			keep = (bits_reg < 8) ? 8 : (bits_reg > 16) ? 16 : bits_reg;
			scale = (range_reg < 1) ? 1 : (range_reg > 16) ? 16 : range_reg;
			mask = 16'hFFFF << (16 - keep);
			words[0] = s.x_word;
			words[1] = s.y_word;
			words[2] = s.z_word;
			sum = 0;
			for (int k = 0; k < 3; k++) begin
				aligned[k] = longint'($signed(words[k] & mask));
				sum += aligned[k] * aligned[k];
			end
			r.x_accel = 20'(aligned[0] * scale);
			r.y_accel = 20'(aligned[1] * scale);
			r.z_accel = 20'(aligned[2] * scale);
			r.zero_vector = (sum == 0);
			r.x_cosine = 0;
			r.y_cosine = 0;
			r.z_cosine = 0;
			if (sum != 0) begin
				root = root_floor(sum);
				for (int k = 0; k < 3; k++) begin
					mag = aligned[k] < 0 ? -aligned[k] : aligned[k];
					q = (mag << 14) / root;
					if (q > 16384)
						q = 16384;
					if (aligned[k] < 0)
						q = -q;
					case (k)
						0: r.x_cosine = 16'(q);
						1: r.y_cosine = 16'(q);
						default: r.z_cosine = 16'(q);
					endcase
				end
			end
			return r;
		end
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		begin
			$display("mismatch on %s: got %0d expected %0d at %0t", what, got, want, $realtime);
			error_count++;
		end
	endtask

	// Request driver: pops the pending queue, predicts on acceptance.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_req <= '0;
		end else begin
			if (in_valid && in_ready)
				expected_rsp.insert(expected_rsp.size(), normalize_sample(in_req));
			if ((!in_valid || in_ready) && sample_queue.size() > 0
					&& $urandom_range(99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				in_req <= sample_queue.pop_front();
			end else if (in_valid && in_ready) begin
				in_valid <= 1'b0;
			end
		end
	end

	// Configuration driver: writes one register when asked.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_valid <= 1'b0;
			cfg_index <= '0;
			cfg_data <= '0;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_BITS_IN_USE)
				bits_reg <= cfg_data;
			else if (cfg_index == CFG_G_RANGE)
				range_reg <= cfg_data;
			cfg_valid <= 1'b0;
			config_pending <= 1'b0;
		end else if (config_pending && !cfg_valid) begin
			cfg_valid <= 1'b1;
			cfg_index <= config_index;
			cfg_data <= config_data;
		end
	end

	// Result monitor and receiver stalls.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				result_count++;
				if (expected_rsp.size() == 0) begin
					report_mismatch("unexpected result", 0, 0);
				end else begin
					out_rsp_t e;
					e = expected_rsp.pop_front();
					if (out_rsp.x_accel !== e.x_accel)
						report_mismatch("x_accel", out_rsp.x_accel, e.x_accel);
					if (out_rsp.y_accel !== e.y_accel)
						report_mismatch("y_accel", out_rsp.y_accel, e.y_accel);
					if (out_rsp.z_accel !== e.z_accel)
						report_mismatch("z_accel", out_rsp.z_accel, e.z_accel);
					if (out_rsp.x_cosine !== e.x_cosine)
						report_mismatch("x_cosine", out_rsp.x_cosine, e.x_cosine);
					if (out_rsp.y_cosine !== e.y_cosine)
						report_mismatch("y_cosine", out_rsp.y_cosine, e.y_cosine);
					if (out_rsp.z_cosine !== e.z_cosine)
						report_mismatch("z_cosine", out_rsp.z_cosine, e.z_cosine);
					if (out_rsp.zero_vector !== e.zero_vector)
						report_mismatch("zero_vector", out_rsp.zero_vector, e.zero_vector);
				end
			end
			if (hold_cycles > 0) begin
				hold_cycles--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	task automatic write_register(input logic [3:0] idx, input logic [4:0] val);
		begin
			config_index = idx;
			config_data = val;
			config_pending = 1'b1;
			while (config_pending)
				@(posedge clk);
		end
	endtask

	task automatic wait_drained;
		begin
			while (sample_queue.size() > 0 || in_valid || expected_rsp.size() > 0)
				@(posedge clk);
		end
	endtask

	function automatic in_req_t random_sample;
		in_req_t s;
		begin
			s = in_req_t'(48'({$urandom, $urandom}));
			// Small vectors now and then, so that alignment can zero whole axes.
			if ($urandom_range(9) == 0) begin
				s.x_word = 16'($signed($urandom_range(511)) - 256);
				s.y_word = 16'($signed($urandom_range(511)) - 256);
				s.z_word = 16'($signed($urandom_range(511)) - 256);
			end
			return s;
		end
	endfunction

	task automatic queue_sample(input logic [15:0] x, input logic [15:0] y,
			input logic [15:0] z);
		in_req_t s;
		begin
			s.x_word = x;
			s.y_word = y;
			s.z_word = z;
			sample_queue.insert(sample_queue.size(), s);
		end
	endtask

	// Stimulus.
	initial begin
		int bits_set[6];
		int range_set[6];
		arst_n = 1'b0;
		error_count = 0;
		result_count = 0;
		send_idle_pct = 27;
		recv_idle_pct = 79;
		hold_cycles = 0;
		config_pending = 1'b0;
		bits_reg = 5'd14;
		range_reg = 5'd2;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, zero vectors, single axes and flag-only words.
		queue_sample(16'h0000, 16'h0000, 16'h0000);
		queue_sample(16'h0003, 16'h0002, 16'h0001);
		queue_sample(16'h7FFF, 16'h7FFF, 16'h7FFF);
		queue_sample(16'h8000, 16'h8000, 16'h8000);
		queue_sample(16'h8000, 16'h0000, 16'h0000);
		queue_sample(16'h0000, 16'h7FFF, 16'h0000);
		queue_sample(16'h0000, 16'h0000, 16'h8000);
		queue_sample(16'hFFFF, 16'hFFFF, 16'hFFFF);
		queue_sample(16'h7FFF, 16'h8000, 16'h0004);
		queue_sample(16'h5555, 16'hAAAA, 16'h1234);
		queue_sample(16'h0004, 16'h0000, 16'hFFFC);
		wait_drained();

		// Saturation of both registers at each end, then an unused index.
		write_register(CFG_BITS_IN_USE, 5'd31);
		write_register(CFG_G_RANGE, 5'd0);
		queue_sample(16'h0001, 16'hFFFF, 16'h8001);
		queue_sample(16'h7FFF, 16'h8000, 16'h0001);
		queue_sample(16'h0001, 16'h0000, 16'h0000);
		wait_drained();
		write_register(CFG_BITS_IN_USE, 5'd0);
		write_register(CFG_G_RANGE, 5'd31);
		write_register(CFG_UNUSED, 5'd3);
		queue_sample(16'h00FF, 16'h0080, 16'h7FFF);
		queue_sample(16'h8000, 16'h8000, 16'h8000);
		queue_sample(16'h0100, 16'hFF00, 16'h0000);
		wait_drained();

		// Random phases over several register settings.
		bits_set = '{16, 8, 12, 14, 16, 10};
		range_set = '{16, 1, 5, 2, 8, 16};
		for (int p = 0; p < 6; p++) begin
			write_register(CFG_BITS_IN_USE, 5'(bits_set[p]));
			write_register(CFG_G_RANGE, 5'(range_set[p]));
			if (p == 2) begin
				send_idle_pct = 79;
				recv_idle_pct = 27;
			end else if (p == 4) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			// Long receiver hold-off while requests keep coming.
			if (p == 1)
				hold_cycles = 200;
			for (int i = 0; i < 120; i++)
				sample_queue.insert(sample_queue.size(), random_sample());
			wait_drained();
		end

		repeat (LATENCY + 10) @(posedge clk);
		$display("Covered %0d results across directed extremes and six register settings,",
			result_count);
		$display("with sender and receiver stalls and a long output back-pressure window.");
		if (error_count == 0 && expected_rsp.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// Timeout.
	initial begin
		#20000000;
		$display("FAILURE");
		$finish;
	end

endmodule
`default_nettype wire
